// ----- rtl/core/scroll_and_flash_notifier_defines.svh -----
// Assertion macros shared by the notifier RTL.
// Plain text only; include from inside a module body.
`ifndef SCROLL_AND_FLASH_NOTIFIER_DEFINES_SVH
`define SCROLL_AND_FLASH_NOTIFIER_DEFINES_SVH

// Check cons in the same cycle as ante, outside reset.
`define SFN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("notifier assertion failed");

// Check cons in the cycle after ante, outside reset.
`define SFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("notifier assertion failed");

`endif

// ----- rtl/core/sfn_pkg.sv -----
// Shared types, codes and constants of the scroll and flash notifier.
// No dependencies; used by the channel interfaces and the notifier module.
package sfn_pkg;

  // Payload widths
  localparam int NOTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int SPEED_W     = 8;
  localparam int FLASH_W     = 4;
  localparam int SECS_W      = 5;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF       = 16;
  localparam int FRAMES_PER_SECOND_DEF = 40;

  // Register value limits
  localparam int MIN_STRIP_WIDTH = 64;
  localparam int MAX_FLASHES     = 10;
  localparam int MAX_SECONDS     = 30;

  // Border flash timing: lit for FLASH_ON frames of a FLASH_PERIOD cycle
  localparam int FLASH_ON     = 6;
  localparam int FLASH_PERIOD = 12;

  // Register reset values
  localparam int SPEED_RST = 1;
  localparam int WIDTH_RST = 64;
  localparam int FLASH_RST = 3;
  localparam int SECS_RST  = 5;

  // Operation codes of an input word
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_ENQUEUE = 1'b1
  } sfn_op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SPEED    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_COUNT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_SECONDS = 8'd3;

endpackage

// ----- rtl/core/sfn_channels.sv -----
// Valid/ready channel interfaces of the notifier: input, result, config.
// Depends on sfn_pkg for payload widths.
interface sfn_in_if import sfn_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              op;
  logic [NOTE_W-1:0] note_id;

  modport source (output valid, output op, output note_id, input ready);
  modport sink   (input valid, input op, input note_id, output ready);
endinterface

interface sfn_out_if import sfn_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  scroll_pos;
  logic              notify_active;
  logic [NOTE_W-1:0] active_id;
  logic              border_on;
  logic              dropped;

  modport source (output valid, output scroll_pos, output notify_active,
                  output active_id, output border_on, output dropped, input ready);
  modport sink   (input valid, input scroll_pos, input notify_active,
                  input active_id, input border_on, input dropped, output ready);
endinterface

interface sfn_cfg_if import sfn_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sfn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module sfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/scroll_and_flash_notifier.sv -----
// Scroll and flash notifier: frame-tick controller with a notification queue.
// Depends on sfn_pkg, sfn_channels (interfaces) and sfn_ram.
//
// Usage:
//   in_ch  carries one word per frame tick (op = tick) or per notification
//          handle to queue (op = enqueue, note_id = handle).
//   out_ch returns exactly one word per input word: scroll position, active
//          notification, border state and a drop flag for a refused enqueue.
//   cfg_ch writes scroll speed, strip width, flash count and display time by
//          register index; unknown indexes are ignored. Write only when idle.
// Timing: an accepted word produces its result in the output register on the
//   next cycle. One word is accepted every cycle unless out_ch stalls; the
//   rate is set by the single state-update stage between the input and output
//   registers. The handle RAM read port prefetches the next head entry.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready drops; the
//   held result stays stable until taken. cfg_ch is always ready.
// Reset: synchronous active-low rst_n returns registers to defaults, empties
//   the queue and goes idle at scroll position 0. No clearing pass is needed.
`include "scroll_and_flash_notifier_defines.svh"

module scroll_and_flash_notifier import sfn_pkg::*; #(
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
  parameter int FRAMES_PER_SECOND = FRAMES_PER_SECOND_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfn_in_if.sink    in_ch,
  sfn_out_if.source out_ch,
  sfn_cfg_if.sink   cfg_ch
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = QW + 1;
  localparam int FW = $clog2(MAX_SECONDS * FRAMES_PER_SECOND + 1);

  // Configuration registers
  logic [SPEED_W-1:0] speed_r;
  logic [POS_W-1:0]   width_r;
  logic [FLASH_W-1:0] flash_cnt_r;
  logic [SECS_W-1:0]  secs_r;

  // Notifier state
  logic [POS_W-1:0]   scroll_r,   scroll_nxt;
  logic [1:0]         accum_r,    accum_nxt;
  logic               showing_r,  showing_nxt;
  logic [NOTE_W-1:0]  handle_r,   handle_nxt;
  logic [FW-1:0]      frames_r,   frames_nxt;
  logic [FLASH_W-1:0] flashes_r,  flashes_nxt;
  logic [FLASH_W-1:0] phase_r,    phase_nxt;
  logic               lit_r,      lit_nxt;
  logic [CW-1:0]      cnt_r,      cnt_nxt;
  logic [QW-1:0]      head_r,     head_nxt;
  logic               byp_r,      byp_nxt;
  logic [NOTE_W-1:0]  byp_data_r;

  // Output register
  logic               ov_r;
  logic [POS_W-1:0]   o_pos_r;
  logic               o_active_r;
  logic [NOTE_W-1:0]  o_id_r;
  logic               o_border_r;
  logic               o_drop_r;

  logic               in_fire;
  logic               cfg_fire;
  logic               drop_nxt;
  logic               we;
  logic [QW-1:0]      slot;
  logic [SW-1:0]      slot_sum;
  logic [QW-1:0]      head_inc;
  logic [NOTE_W-1:0]  ram_rdata;
  logic [NOTE_W-1:0]  head_data;

  logic [SPEED_W-1:0] speed_eff;
  logic [POS_W-1:0]   width_eff;
  logic [FLASH_W-1:0] flash_eff;
  logic [SECS_W-1:0]  secs_eff;
  logic [FW-1:0]      note_frames;
  logic [9:0]         acc_sum;
  logic [POS_W:0]     pos_sum;
  logic [POS_W:0]     pos_wrap;
  logic [POS_W-1:0]   scroll_step;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = !ov_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Clamp register values to their legal ranges
  assign speed_eff = (speed_r == '0) ? SPEED_W'(1) : speed_r;
  assign width_eff = (width_r < POS_W'(MIN_STRIP_WIDTH)) ? POS_W'(MIN_STRIP_WIDTH) : width_r;
  assign flash_eff = (flash_cnt_r == '0) ? FLASH_W'(1) :
                     (flash_cnt_r > FLASH_W'(MAX_FLASHES)) ? FLASH_W'(MAX_FLASHES) :
                     flash_cnt_r;
  assign secs_eff  = (secs_r == '0) ? SECS_W'(1) :
                     (secs_r > SECS_W'(MAX_SECONDS)) ? SECS_W'(MAX_SECONDS) : secs_r;
  assign note_frames = FW'(32'(secs_eff) * FRAMES_PER_SECOND);

  // Scroll step: add speed to the quarter accumulator, wrap at the strip width
  assign acc_sum     = 10'(accum_r) + 10'(speed_eff);
  assign pos_sum     = (POS_W + 1)'(scroll_r) + (POS_W + 1)'(acc_sum[9:2]);
  assign pos_wrap    = (pos_sum >= (POS_W + 1)'(width_eff)) ?
                       pos_sum - (POS_W + 1)'(width_eff) : pos_sum;
  assign scroll_step = (pos_wrap >= (POS_W + 1)'(width_eff)) ? '0 : pos_wrap[POS_W-1:0];

  // Queue addressing: tail slot and next head, both wrapping at the depth
  assign slot_sum  = SW'(head_r) + SW'(cnt_r);
  assign slot      = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                     QW'(slot_sum - SW'(QUEUE_DEPTH)) : QW'(slot_sum);
  assign head_inc  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
  assign head_data = byp_r ? byp_data_r : ram_rdata;

  sfn_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (in_ch.note_id),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // Next-state logic for one tick or enqueue
  always_comb begin
    logic [FW-1:0] frames_dec;
    frames_dec  = (frames_r != '0) ? frames_r - FW'(1) : frames_r;
    scroll_nxt  = scroll_r;
    accum_nxt   = accum_r;
    showing_nxt = showing_r;
    handle_nxt  = handle_r;
    frames_nxt  = frames_r;
    flashes_nxt = flashes_r;
    phase_nxt   = phase_r;
    lit_nxt     = lit_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    drop_nxt    = 1'b0;
    we          = 1'b0;
    if (in_fire) begin
      if (in_ch.op == OP_TICK) begin
        if (showing_r) begin
          frames_nxt = frames_dec;
          if (frames_dec == '0) begin
            if (cnt_r == '0) begin
              // drop back to scrolling
              showing_nxt = 1'b0;
              handle_nxt  = '0;
              frames_nxt  = '0;
              flashes_nxt = '0;
              phase_nxt   = '0;
              lit_nxt     = 1'b0;
            end else begin
              // pop the next queued handle
              showing_nxt = 1'b1;
              handle_nxt  = head_data;
              frames_nxt  = note_frames;
              flashes_nxt = flash_eff;
              phase_nxt   = '0;
              lit_nxt     = 1'b1;
              head_nxt    = head_inc;
              cnt_nxt     = cnt_r - CW'(1);
            end
          end else if (flashes_r != '0) begin
            if (phase_r == FLASH_W'(FLASH_PERIOD - 1)) begin
              flashes_nxt = flashes_r - FLASH_W'(1);
              phase_nxt   = '0;
              lit_nxt     = 1'b1;
            end else begin
              phase_nxt = phase_r + FLASH_W'(1);
              lit_nxt   = (phase_r < FLASH_W'(FLASH_ON - 1));
            end
          end
        end else begin
          scroll_nxt = scroll_step;
          accum_nxt  = acc_sum[1:0];
        end
      end else if (!showing_r && cnt_r == '0) begin
        // show the handle at once
        showing_nxt = 1'b1;
        handle_nxt  = in_ch.note_id;
        frames_nxt  = note_frames;
        flashes_nxt = flash_eff;
        phase_nxt   = '0;
        lit_nxt     = 1'b1;
      end else if (cnt_r >= CW'(QUEUE_DEPTH)) begin
        drop_nxt = 1'b1;
      end else begin
        we      = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (!showing_r) begin
          // queue was not empty while idle: start its head
          showing_nxt = 1'b1;
          handle_nxt  = head_data;
          frames_nxt  = note_frames;
          flashes_nxt = flash_eff;
          phase_nxt   = '0;
          lit_nxt     = 1'b1;
          head_nxt    = head_inc;
          cnt_nxt     = cnt_r;
        end
      end
    end
    // forward a write that lands on the prefetched head entry
    byp_nxt = we && (slot == head_nxt);
  end

  // State, configuration and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_W'(SPEED_RST);
      width_r     <= POS_W'(WIDTH_RST);
      flash_cnt_r <= FLASH_W'(FLASH_RST);
      secs_r      <= SECS_W'(SECS_RST);
      scroll_r    <= '0;
      accum_r     <= '0;
      showing_r   <= 1'b0;
      handle_r    <= '0;
      frames_r    <= '0;
      flashes_r   <= '0;
      phase_r     <= '0;
      lit_r       <= 1'b0;
      cnt_r       <= '0;
      head_r      <= '0;
      byp_r       <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_SCROLL_SPEED:    speed_r     <= cfg_ch.data[SPEED_W-1:0];
          REG_STRIP_WIDTH:     width_r     <= cfg_ch.data[POS_W-1:0];
          REG_FLASH_COUNT:     flash_cnt_r <= cfg_ch.data[FLASH_W-1:0];
          REG_DISPLAY_SECONDS: secs_r      <= cfg_ch.data[SECS_W-1:0];
          default: ;
        endcase
      end
      scroll_r  <= scroll_nxt;
      accum_r   <= accum_nxt;
      showing_r <= showing_nxt;
      handle_r  <= handle_nxt;
      frames_r  <= frames_nxt;
      flashes_r <= flashes_nxt;
      phase_r   <= phase_nxt;
      lit_r     <= lit_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      byp_r     <= byp_nxt;
      if (in_fire) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Result payload and bypass data
  always_ff @(posedge clk) begin
    byp_data_r <= in_ch.note_id;
    if (in_fire) begin
      o_pos_r    <= scroll_nxt;
      o_active_r <= showing_nxt;
      o_id_r     <= showing_nxt ? handle_nxt : '0;
      o_border_r <= showing_nxt && (flashes_nxt != '0) && lit_nxt;
      o_drop_r   <= drop_nxt;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.scroll_pos    = o_pos_r;
  assign out_ch.notify_active = o_active_r;
  assign out_ch.active_id     = o_id_r;
  assign out_ch.border_on     = o_border_r;
  assign out_ch.dropped       = o_drop_r;

  // Queue never overfills
  `SFN_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(QUEUE_DEPTH))
  // Idle means nothing is waiting in the queue
  `SFN_ASSERT_SAME(a_idle_empty, clk, rst_n, !showing_r, cnt_r == '0)
  // Enqueue on a full queue is reported as dropped
  `SFN_ASSERT_NEXT(a_drop_full, clk, rst_n,
    in_fire && (in_ch.op == OP_ENQUEUE) && (cnt_r == CW'(QUEUE_DEPTH)), o_drop_r && ov_r)
  // Idle result carries no handle and no border
  `SFN_ASSERT_SAME(a_idle_out, clk, rst_n, ov_r && !o_active_r,
    (o_id_r == '0) && !o_border_r)

endmodule
